// ----- rtl/ordered_timer_queue_core_macros.svh -----
// Assertion helpers used by the checker file otq_checker.sv.
`ifndef ORDERED_TIMER_QUEUE_CORE_MACROS_SVH
`define ORDERED_TIMER_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define OTQ_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define OTQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/otq_pkg.sv -----
`timescale 1ns / 1ps

package otq_pkg;

    // Table size and per-expire fire limit
    localparam int OTQ_DEPTH  = 16;
    localparam int MAX_FIRE   = 16;
    localparam int FIRE_CNT_W = $clog2(MAX_FIRE + 1);

    // Field widths
    localparam int OP_W   = 2;
    localparam int TIME_W = 48;
    localparam int IVL_W  = 32;
    localparam int ID_W   = 32;
    localparam int CAP_W  = 27;
    localparam int TMO_W  = 28;
    localparam int KIND_W = 3;

    // One day in milliseconds
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(24 * 60 * 60 * 1000);

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED     = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_FIRED     = 3'd4,
        KIND_NONE_DUE  = 3'd5,
        KIND_TIMEOUT   = 3'd6
    } kind_t;

    // One timer table entry
    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [IVL_W-1:0]  interval;
        logic [ID_W-1:0]   id;
    } entry_t;

    // Compare unit results
    typedef struct packed {
        logic due;       // candidate expiry <= now
        logic exp_lt;    // candidate expiry < best expiry
        logic order_lt;  // candidate before best by (expiry, id)
        logic id_match;  // candidate id == key
    } cmp_t;

endpackage

// ----- rtl/ordered_timer_queue_core.sv -----
`timescale 1ns / 1ps
// Ordered timer queue: a table of DEPTH timers with repeat support.
// Input channel s_*: one command word per handshake (add, cancel, expire, query).
// Result channel m_*: one or more result words per command, m_last on the final one.
// Config channel cfg_*: writes the query cap; always ready, take effect at once.
// Commands run one at a time; s_ready is high only while the block is idle.
// Steps per command; every table scan reads one entry per cycle from a table
// memory with registered read data:
//   add     : walks the valid bits for the lowest free slot
//   cancel  : one scan for the entry with the given id
//   query   : one scan, then a clamp to the cap unless the table is empty
//   expire  : one scan per fired timer plus a closing scan that finds none due,
//             at most 16 timers fired per command; after the sixteenth fire the
//             closing scan is skipped and the final word follows
// A result word waits in the output register until taken; a stalled receiver
// holds the sequencer at its next result, nothing is dropped.
// Reset clears all slots, sets the next id to one and the cap to one day.
// No clearing pass follows reset: valid bits are flip-flops.
module ordered_timer_queue_core #(
    parameter int DEPTH = otq_pkg::OTQ_DEPTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [otq_pkg::OP_W-1:0]              s_op,
    input  logic [otq_pkg::TIME_W-1:0]            s_now_ms,
    input  logic [otq_pkg::TIME_W-1:0]            s_first_expiry_ms,
    input  logic [otq_pkg::IVL_W-1:0]             s_interval_ms,
    input  logic [otq_pkg::ID_W-1:0]              s_cancel_id,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [otq_pkg::KIND_W-1:0]            m_kind,
    output logic [otq_pkg::ID_W-1:0]              m_timer_id,
    output logic signed [otq_pkg::TMO_W-1:0]      m_timeout_ms,
    output logic                                  m_last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [otq_pkg::CAP_W-1:0]             cfg_timeout_cap_ms
);
    import otq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_DECIDE,
        ST_QCAP
    } state_t;

    state_t              state_reg;
    op_t                 op_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   first_reg;
    logic [IVL_W-1:0]    ivl_reg;
    logic [ID_W-1:0]     cid_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [ID_W-1:0]     next_id_reg;
    logic [DEPTH-1:0]    slot_valid_reg;
    logic [DEPTH-1:0]    fired_reg;

    logic [IW-1:0]       scan_idx_reg;
    logic                scan_run_reg;
    logic                rd_vld_reg;
    logic [IW-1:0]       rd_idx_reg;
    entry_t              rd_data_reg;
    entry_t              mem [DEPTH];

    logic                best_vld_reg;
    logic [IW-1:0]       best_idx_reg;
    logic [TIME_W-1:0]   best_exp_reg;
    logic [ID_W-1:0]     best_id_reg;
    logic [IVL_W-1:0]    best_ivl_reg;
    logic                pend_vld_reg;
    logic [ID_W-1:0]     pend_id_reg;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg;
    logic [TIME_W:0]     diff_reg;

    logic                out_put_reg;
    logic                out_take_reg;
    kind_t               out_kind_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [TMO_W-1:0]    out_tmo_reg;
    logic                out_last_reg;

    cmp_t                cmp;
    logic                out_vld;
    logic                out_free;
    logic                take;
    logic                add_go;
    logic                fire_go;
    logic                wr_en;
    logic [IW-1:0]       wr_idx;
    entry_t              wr_data;
    logic [TIME_W:0]     sum_wide;
    logic [TIME_W-1:0]   new_exp;
    logic [ID_W-1:0]     next_id_inc;
    logic [FIRE_CNT_W-1:0] fire_cnt_inc;
    logic [CAP_W-1:0]    cap_eff;
    logic                q_due;
    logic [CAP_W-1:0]    q_left;

    // Output word is held while the load and take toggles differ
    assign out_vld = out_put_reg ^ out_take_reg;

    // Ports
    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = out_vld;
    assign m_kind       = out_kind_reg;
    assign m_timer_id   = out_id_reg;
    assign m_timeout_ms = out_tmo_reg;
    assign m_last       = out_last_reg;

    assign out_free = !out_vld || m_ready;

    // Shared compare unit: current read entry against the best so far
    otq_cmp u_cmp (
        .cand_exp (rd_data_reg.expiry),
        .cand_id  (rd_data_reg.id),
        .best_exp (best_exp_reg),
        .best_id  (best_id_reg),
        .now_ms   (now_reg),
        .key_id   (cid_reg),
        .res      (cmp)
    );

    // Scan selection per command
    always_comb begin
        case (op_reg)
            OP_CANCEL: take = rd_vld_reg && slot_valid_reg[rd_idx_reg] && cmp.id_match
                              && (cid_reg != '0) && !best_vld_reg;
            OP_EXPIRE: take = rd_vld_reg && slot_valid_reg[rd_idx_reg]
                              && !fired_reg[rd_idx_reg] && cmp.due
                              && (!best_vld_reg || cmp.order_lt);
            OP_QUERY:  take = rd_vld_reg && slot_valid_reg[rd_idx_reg]
                              && (!best_vld_reg || cmp.exp_lt);
            default:   take = 1'b0;
        endcase
    end

    // Table write triggers
    assign add_go  = (state_reg == ST_ADD) && !slot_valid_reg[scan_idx_reg] && out_free;
    assign fire_go = (state_reg == ST_DECIDE) && (op_reg == OP_EXPIRE) && best_vld_reg
                     && (!pend_vld_reg || out_free);

    // Repeat rearm, saturating at the top of the time range
    assign sum_wide = {1'b0, now_reg} + (TIME_W + 1)'(best_ivl_reg);
    assign new_exp  = sum_wide[TIME_W] ? {TIME_W{1'b1}} : sum_wide[TIME_W-1:0];

    // Id counter skips zero
    assign next_id_inc  = (next_id_reg + 1'b1 == '0) ? ID_W'(1) : next_id_reg + 1'b1;
    assign fire_cnt_inc = fire_cnt_reg + 1'b1;

    // Query cap and answer
    assign cap_eff = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign q_due   = diff_reg[TIME_W] || (diff_reg == '0);
    assign q_left  = (diff_reg < (TIME_W + 1)'(cap_eff)) ? diff_reg[CAP_W-1:0] : cap_eff;

    // Table write port
    always_comb begin
        wr_en   = add_go || (fire_go && (best_ivl_reg != '0));
        wr_idx  = add_go ? scan_idx_reg : best_idx_reg;
        wr_data = add_go ? entry_t'{expiry: first_reg, interval: ivl_reg, id: next_id_reg}
                         : entry_t'{expiry: new_exp, interval: best_ivl_reg, id: best_id_reg};
    end

    // Timer table memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[scan_idx_reg];
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CAP_RESET;
            next_id_reg    <= ID_W'(1);
            slot_valid_reg <= '0;
            fired_reg      <= '0;
            scan_run_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
            best_vld_reg   <= 1'b0;
            pend_vld_reg   <= 1'b0;
            fire_cnt_reg   <= '0;
            out_put_reg    <= 1'b0;
            out_take_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_timeout_cap_ms;
            end
            if (out_vld && m_ready) begin
                out_take_reg <= !out_take_reg;
            end
            rd_vld_reg <= scan_run_reg;
            rd_idx_reg <= scan_idx_reg;

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg       <= op_t'(s_op);
                        now_reg      <= s_now_ms;
                        first_reg    <= s_first_expiry_ms;
                        ivl_reg      <= s_interval_ms;
                        cid_reg      <= s_cancel_id;
                        scan_idx_reg <= '0;
                        best_vld_reg <= 1'b0;
                        pend_vld_reg <= 1'b0;
                        fire_cnt_reg <= '0;
                        fired_reg    <= '0;
                        if (op_t'(s_op) == OP_ADD) begin
                            state_reg <= ST_ADD;
                        end else begin
                            scan_run_reg <= 1'b1;
                            state_reg    <= ST_SCAN;
                        end
                    end
                end

                // Walk valid bits for the lowest free slot
                ST_ADD: begin
                    if (add_go) begin
                        slot_valid_reg[scan_idx_reg] <= 1'b1;
                        next_id_reg  <= next_id_inc;
                        out_put_reg  <= !out_put_reg;
                        out_kind_reg <= KIND_ADDED;
                        out_id_reg   <= next_id_reg;
                        out_tmo_reg  <= '0;
                        out_last_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end else if (slot_valid_reg[scan_idx_reg]) begin
                        if (scan_idx_reg == LAST_IDX) begin
                            if (out_free) begin
                                out_put_reg  <= !out_put_reg;
                                out_kind_reg <= KIND_FULL;
                                out_id_reg   <= '0;
                                out_tmo_reg  <= '0;
                                out_last_reg <= 1'b1;
                                state_reg    <= ST_IDLE;
                            end
                        end else begin
                            scan_idx_reg <= scan_idx_reg + 1'b1;
                        end
                    end
                end

                // One entry per cycle through the compare unit
                ST_SCAN: begin
                    if (scan_run_reg) begin
                        if (scan_idx_reg == LAST_IDX) begin
                            scan_run_reg <= 1'b0;
                        end else begin
                            scan_idx_reg <= scan_idx_reg + 1'b1;
                        end
                    end
                    if (take) begin
                        best_vld_reg <= 1'b1;
                        best_idx_reg <= rd_idx_reg;
                        best_exp_reg <= rd_data_reg.expiry;
                        best_id_reg  <= rd_data_reg.id;
                        best_ivl_reg <= rd_data_reg.interval;
                    end
                    if (rd_vld_reg && (rd_idx_reg == LAST_IDX)) begin
                        state_reg <= ST_DECIDE;
                    end
                end

                ST_DECIDE: begin
                    case (op_reg)
                        OP_CANCEL: begin
                            if (out_free) begin
                                out_put_reg  <= !out_put_reg;
                                out_tmo_reg  <= '0;
                                out_last_reg <= 1'b1;
                                if (best_vld_reg) begin
                                    slot_valid_reg[best_idx_reg] <= 1'b0;
                                    out_kind_reg <= KIND_CANCELLED;
                                    out_id_reg   <= cid_reg;
                                end else begin
                                    out_kind_reg <= KIND_NOT_FOUND;
                                    out_id_reg   <= '0;
                                end
                                state_reg <= ST_IDLE;
                            end
                        end

                        // Fired id is held back one round so the final one gets last
                        OP_EXPIRE: begin
                            if (best_vld_reg) begin
                                if (fire_go) begin
                                    if (pend_vld_reg) begin
                                        out_put_reg  <= !out_put_reg;
                                        out_kind_reg <= KIND_FIRED;
                                        out_id_reg   <= pend_id_reg;
                                        out_tmo_reg  <= '0;
                                        out_last_reg <= 1'b0;
                                    end
                                    pend_vld_reg           <= 1'b1;
                                    pend_id_reg            <= best_id_reg;
                                    fired_reg[best_idx_reg] <= 1'b1;
                                    if (best_ivl_reg == '0) begin
                                        slot_valid_reg[best_idx_reg] <= 1'b0;
                                    end
                                    fire_cnt_reg <= fire_cnt_inc;
                                    best_vld_reg <= 1'b0;
                                    if (fire_cnt_inc != FIRE_CNT_W'(MAX_FIRE)) begin
                                        scan_idx_reg <= '0;
                                        scan_run_reg <= 1'b1;
                                        state_reg    <= ST_SCAN;
                                    end
                                end
                            end else if (out_free) begin
                                out_put_reg  <= !out_put_reg;
                                out_kind_reg <= pend_vld_reg ? KIND_FIRED : KIND_NONE_DUE;
                                out_id_reg   <= pend_vld_reg ? pend_id_reg : '0;
                                out_tmo_reg  <= '0;
                                out_last_reg <= 1'b1;
                                pend_vld_reg <= 1'b0;
                                state_reg    <= ST_IDLE;
                            end
                        end

                        OP_QUERY: begin
                            if (best_vld_reg) begin
                                diff_reg  <= {1'b0, best_exp_reg} - {1'b0, now_reg};
                                state_reg <= ST_QCAP;
                            end else if (out_free) begin
                                out_put_reg  <= !out_put_reg;
                                out_kind_reg <= KIND_TIMEOUT;
                                out_id_reg   <= '0;
                                out_tmo_reg  <= {TMO_W{1'b1}};
                                out_last_reg <= 1'b1;
                                state_reg    <= ST_IDLE;
                            end
                        end

                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end

                // Clamp time left to the cap
                ST_QCAP: begin
                    if (out_free) begin
                        out_put_reg  <= !out_put_reg;
                        out_kind_reg <= KIND_TIMEOUT;
                        out_id_reg   <= '0;
                        out_tmo_reg  <= q_due ? '0 : TMO_W'(q_left);
                        out_last_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/otq_cmp.sv -----
`timescale 1ns / 1ps

module otq_cmp (
    input  logic [otq_pkg::TIME_W-1:0] cand_exp,
    input  logic [otq_pkg::ID_W-1:0]   cand_id,
    input  logic [otq_pkg::TIME_W-1:0] best_exp,
    input  logic [otq_pkg::ID_W-1:0]   best_id,
    input  logic [otq_pkg::TIME_W-1:0] now_ms,
    input  logic [otq_pkg::ID_W-1:0]   key_id,
    output otq_pkg::cmp_t              res
);
    import otq_pkg::*;

    logic exp_eq;
    logic exp_lt;
    logic id_lt;

    // Shared compares used by the expire and query scans
    assign exp_eq = (cand_exp == best_exp);
    assign exp_lt = (cand_exp < best_exp);
    assign id_lt  = (cand_id < best_id);

    assign res.due      = (cand_exp <= now_ms);
    assign res.exp_lt   = exp_lt;
    assign res.order_lt = exp_lt || (exp_eq && id_lt);
    assign res.id_match = (cand_id == key_id);

endmodule

// ----- rtl/otq_checker.sv -----
`timescale 1ns / 1ps
`include "ordered_timer_queue_core_macros.svh"

module otq_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [otq_pkg::OP_W-1:0]         s_op,
    input logic [otq_pkg::TIME_W-1:0]       s_now_ms,
    input logic [otq_pkg::TIME_W-1:0]       s_first_expiry_ms,
    input logic [otq_pkg::IVL_W-1:0]        s_interval_ms,
    input logic [otq_pkg::ID_W-1:0]         s_cancel_id,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [otq_pkg::KIND_W-1:0]       m_kind,
    input logic [otq_pkg::ID_W-1:0]         m_timer_id,
    input logic signed [otq_pkg::TMO_W-1:0] m_timeout_ms,
    input logic                             m_last,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [otq_pkg::CAP_W-1:0]        cfg_timeout_cap_ms
);
    import otq_pkg::*;

    // A stalled result word holds
    `OTQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_timer_id) && $stable(m_timeout_ms) && $stable(m_last), "result word changed while stalled")

    // A command keeps the block busy for at least the next cycle
    `OTQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input ready right after a command word")

    // Only fired words may be followed by more words of the same command
    `OTQ_ASSERT_SAME(a_single_last, aclk, aresetn, m_valid && (m_kind != KIND_FIRED), m_last, "single-word result without last")

    // Timeout field only carries data on query answers
    `OTQ_ASSERT_SAME(a_tmo_zero, aclk, aresetn, m_valid && (m_kind != KIND_TIMEOUT), m_timeout_ms == '0, "timeout field set outside a query answer")

    // Id zero is never handed out, cancelled or fired
    `OTQ_ASSERT_SAME(a_id_nonzero, aclk, aresetn, m_valid && ((m_kind == KIND_ADDED) || (m_kind == KIND_CANCELLED) || (m_kind == KIND_FIRED)), m_timer_id != '0, "zero timer id reported")

endmodule

bind ordered_timer_queue_core otq_checker u_otq_checker (.*);
